// ===== sv/hsimd_pkg.sv =====
// Package for the packed-integer horizontal SIMD unit.
// Holds the operation and element-size codes, the control bundle and the legality decoder.
// No dependencies.
package hsimd_pkg;

    typedef enum logic [2:0] {
        OP_HADD  = 3'd0,
        OP_HSUB  = 3'd1,
        OP_HADDS = 3'd2,
        OP_HSUBS = 3'd3,
        OP_SAD   = 3'd4,
        OP_ABS   = 3'd5,
        OP_SIGN  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ES_BYTE  = 2'd0,
        ES_WORD  = 2'd1,
        ES_DWORD = 2'd2
    } es_t;

    typedef struct packed {
        op_t op;
        es_t es;
    } ctl_t;

    localparam int HALF_BITS = 64;
    localparam int PAIR_BITS = 32;
    localparam int SAD_BITS  = 11;

    // True when the operation does not exist for the given element size.
    function automatic logic is_bad(input ctl_t ctl);
        logic bad;
        bad = 1'b1;
        unique case (ctl.op)
            OP_HADD, OP_HSUB:   bad = !(ctl.es inside {ES_WORD, ES_DWORD});
            OP_HADDS, OP_HSUBS: bad = (ctl.es != ES_WORD);
            OP_SAD:             bad = (ctl.es != ES_BYTE);
            OP_ABS, OP_SIGN:    bad = !(ctl.es inside {ES_BYTE, ES_WORD, ES_DWORD});
            default:            bad = 1'b1;
        endcase
        return bad;
    endfunction

endpackage

// ===== sv/hsimd_hpair.sv =====
// Horizontal adjacent-pair add and subtract over one 64-bit half, giving 32 packed bits.
// Covers wrapping word and dword forms and the signed-saturating word forms.
// Depends on hsimd_pkg.
module hsimd_hpair (
    input  hsimd_pkg::ctl_t                     ctl,
    input  logic [hsimd_pkg::HALF_BITS-1:0]     src,
    output logic [hsimd_pkg::PAIR_BITS-1:0]     pairs
);

    logic [15:0] word_res [2];
    logic [31:0] dword_res;

    always_comb
    begin
        logic [16:0] e0;
        logic [16:0] e1;
        logic [16:0] s;
        for (int k = 0; k < 2; k++)
        begin
            e0 = {src[32*k+15], src[32*k +: 16]};
            e1 = {src[32*k+31], src[32*k+16 +: 16]};
            if (ctl.op == hsimd_pkg::OP_HSUB || ctl.op == hsimd_pkg::OP_HSUBS)
            begin
                s = e0 - e1;
            end
            else
            begin
                s = e0 + e1;
            end
            // A 17-bit result whose top two bits differ is outside the int16 range.
            if ((ctl.op == hsimd_pkg::OP_HADDS || ctl.op == hsimd_pkg::OP_HSUBS)
                && (s[16] != s[15]))
            begin
                word_res[k] = s[16] ? 16'h8000 : 16'h7fff;
            end
            else
            begin
                word_res[k] = s[15:0];
            end
        end
    end

    always_comb
    begin
        if (ctl.op == hsimd_pkg::OP_HSUB)
        begin
            dword_res = src[31:0] - src[63:32];
        end
        else
        begin
            dword_res = src[31:0] + src[63:32];
        end
    end

    assign pairs = (ctl.es == hsimd_pkg::ES_DWORD) ? dword_res : {word_res[1], word_res[0]};

endmodule

// ===== sv/hsimd_lane.sv =====
// Element-wise operations over one 64-bit half: byte sum of absolute differences,
// absolute value and sign application for bytes, words and dwords.
// Depends on hsimd_pkg.
module hsimd_lane (
    input  hsimd_pkg::ctl_t                     ctl,
    input  logic [hsimd_pkg::HALF_BITS-1:0]     src_a,
    input  logic [hsimd_pkg::HALF_BITS-1:0]     src_b,
    output logic [hsimd_pkg::HALF_BITS-1:0]     result
);

    logic [hsimd_pkg::HALF_BITS-1:0] abs_b, abs_w, abs_d;
    logic [hsimd_pkg::HALF_BITS-1:0] sgn_b, sgn_w, sgn_d;
    logic [hsimd_pkg::SAD_BITS-1:0]  sad_sum;

    always_comb
    begin
        logic [7:0] xb;
        logic [7:0] yb;
        logic [7:0] db;
        sad_sum = '0;
        abs_b   = '0;
        sgn_b   = '0;
        for (int i = 0; i < 8; i++)
        begin
            xb = src_a[8*i +: 8];
            yb = src_b[8*i +: 8];
            db = (xb >= yb) ? (xb - yb) : (yb - xb);
            sad_sum = sad_sum + hsimd_pkg::SAD_BITS'(db);
            abs_b[8*i +: 8] = yb[7] ? (8'd0 - yb) : yb;
            sgn_b[8*i +: 8] = (yb == 8'd0) ? 8'd0 : (yb[7] ? (8'd0 - xb) : xb);
        end
    end

    always_comb
    begin
        logic [15:0] xw;
        logic [15:0] yw;
        abs_w = '0;
        sgn_w = '0;
        for (int i = 0; i < 4; i++)
        begin
            xw = src_a[16*i +: 16];
            yw = src_b[16*i +: 16];
            abs_w[16*i +: 16] = yw[15] ? (16'd0 - yw) : yw;
            sgn_w[16*i +: 16] = (yw == 16'd0) ? 16'd0 : (yw[15] ? (16'd0 - xw) : xw);
        end
    end

    always_comb
    begin
        logic [31:0] xd;
        logic [31:0] yd;
        abs_d = '0;
        sgn_d = '0;
        for (int i = 0; i < 2; i++)
        begin
            xd = src_a[32*i +: 32];
            yd = src_b[32*i +: 32];
            abs_d[32*i +: 32] = yd[31] ? (32'd0 - yd) : yd;
            sgn_d[32*i +: 32] = (yd == 32'd0) ? 32'd0 : (yd[31] ? (32'd0 - xd) : xd);
        end
    end

    always_comb
    begin
        result = '0;
        case (ctl.op)
            hsimd_pkg::OP_SAD:
            begin
                result = hsimd_pkg::HALF_BITS'(sad_sum);
            end
            hsimd_pkg::OP_ABS:
            begin
                case (ctl.es)
                    hsimd_pkg::ES_BYTE:  result = abs_b;
                    hsimd_pkg::ES_WORD:  result = abs_w;
                    default:             result = abs_d;
                endcase
            end
            default:
            begin
                case (ctl.es)
                    hsimd_pkg::ES_BYTE:  result = sgn_b;
                    hsimd_pkg::ES_WORD:  result = sgn_w;
                    default:             result = sgn_d;
                endcase
            end
        endcase
    end

endmodule

// ===== sv/packed_int_horizontal_simd_alu_unit.sv =====
// Packed-integer horizontal SIMD unit, top level: input register, datapath, result register.
// done strobes once a command has passed the input and result registers.
// Throughput: one command per cycle; the single datapath pass sets that figure.
// Reset clears valid and done; busy is high during reset and the cycle after it.
// The receiver cannot stall, so busy stays low in normal operation.
// Depends on hsimd_pkg, hsimd_hpair and hsimd_lane.
module packed_int_horizontal_simd_alu_unit #(
    parameter int VECTOR_BITS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [1:0]  element_size,
    input  logic        wide_mode,
    input  logic [63:0] src_a_low,
    input  logic [63:0] src_a_high,
    input  logic [63:0] src_b_low,
    input  logic [63:0] src_b_high,
    output logic        done,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    output logic        bad_request
);

    localparam bit HAS_WIDE = (VECTOR_BITS >= 128);

    logic            busy_reg;
    logic            busy_next;
    logic            valid_reg;
    logic            valid_next;
    hsimd_pkg::ctl_t ctl_reg;
    logic            wide_reg;
    logic [63:0]     a_lo_reg, a_hi_reg, b_lo_reg, b_hi_reg;

    logic            done_reg;
    logic [63:0]     res_lo_reg, res_hi_reg;
    logic            bad_reg;
    logic [63:0]     res_lo_next, res_hi_next;
    logic            bad_next;

    logic            accept;
    logic [31:0]     pair_a_lo, pair_a_hi, pair_b_lo, pair_b_hi;
    logic [63:0]     lane_lo, lane_hi;

    assign accept     = start && !busy_reg;
    assign busy_next  = 1'b0;
    assign valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg.op <= hsimd_pkg::op_t'(req_type);
            ctl_reg.es <= hsimd_pkg::es_t'(element_size);
            wide_reg   <= wide_mode & HAS_WIDE;
            a_lo_reg   <= src_a_low;
            a_hi_reg   <= src_a_high;
            b_lo_reg   <= src_b_low;
            b_hi_reg   <= src_b_high;
        end
        if (valid_reg)
        begin
            res_lo_reg <= res_lo_next;
            res_hi_reg <= res_hi_next;
            bad_reg    <= bad_next;
        end
    end

    hsimd_hpair u_hpair_a_lo (.ctl(ctl_reg), .src(a_lo_reg), .pairs(pair_a_lo));
    hsimd_hpair u_hpair_a_hi (.ctl(ctl_reg), .src(a_hi_reg), .pairs(pair_a_hi));
    hsimd_hpair u_hpair_b_lo (.ctl(ctl_reg), .src(b_lo_reg), .pairs(pair_b_lo));
    hsimd_hpair u_hpair_b_hi (.ctl(ctl_reg), .src(b_hi_reg), .pairs(pair_b_hi));

    hsimd_lane u_lane_lo (.ctl(ctl_reg), .src_a(a_lo_reg), .src_b(b_lo_reg), .result(lane_lo));
    hsimd_lane u_lane_hi (.ctl(ctl_reg), .src_a(a_hi_reg), .src_b(b_hi_reg), .result(lane_hi));

    // Horizontal results put the pairs of A in the low half of the vector and those of B
    // in the high half; in the 64-bit form both fit in the low qword.
    always_comb
    begin
        bad_next    = hsimd_pkg::is_bad(ctl_reg);
        res_lo_next = '0;
        res_hi_next = '0;
        if (!bad_next)
        begin
            if (ctl_reg.op == hsimd_pkg::OP_HADD || ctl_reg.op == hsimd_pkg::OP_HSUB
                || ctl_reg.op == hsimd_pkg::OP_HADDS || ctl_reg.op == hsimd_pkg::OP_HSUBS)
            begin
                if (wide_reg)
                begin
                    res_lo_next = {pair_a_hi, pair_a_lo};
                    res_hi_next = {pair_b_hi, pair_b_lo};
                end
                else
                begin
                    res_lo_next = {pair_b_lo, pair_a_lo};
                end
            end
            else
            begin
                res_lo_next = lane_lo;
                res_hi_next = wide_reg ? lane_hi : 64'd0;
            end
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign result_low  = res_lo_reg;
    assign result_high = res_hi_reg;
    assign bad_request = bad_reg;

`ifndef SYNTHESIS
    a_done_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("transfer not followed by a result strobe");

    a_done_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(busy, 2)) |-> $past(start, 2))
        else $error("result strobe without a matching transfer");

    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_request) |-> (result_low == 64'd0 && result_high == 64'd0))
        else $error("unsupported request gave a nonzero result");

    a_narrow_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_high != 64'd0) |-> $past(wide_mode, 2))
        else $error("64-bit request gave a nonzero high result");
`endif

endmodule
